FILE: sv/alrc_pkg.sv
// Shared types and constants for the associative LRU mapping cache.
// Used by alrc_cell, assoc_lru_mapping_cache and the testbench; depends on nothing.
package alrc_pkg;

    localparam int SLOTS      = 16;
    localparam int KEY_BITS   = 32;
    localparam int STAMP_BITS = 64;
    localparam int IDX_BITS   = 4;
    localparam int CNT_BITS   = 5;
    localparam int ADDR_BITS  = 3;
    localparam int DATA_BITS  = 32;
    localparam int OUT_BITS   = 40;

    localparam logic [CNT_BITS-1:0] ACTIVE_RESET = CNT_BITS'(SLOTS);
    localparam logic [CNT_BITS-1:0] ACTIVE_MIN   = CNT_BITS'(1);

    // register index, taken from paddr[2]
    localparam logic REG_ACTIVE_SLOTS = 1'b0;

    // search record that walks the chain of cells
    typedef struct packed {
        logic                  pvalid;
        logic [KEY_BITS-1:0]   key;
        logic                  hit;
        logic [IDX_BITS-1:0]   hit_idx;
        logic                  free;
        logic [IDX_BITS-1:0]   free_idx;
        logic                  have_min;
        logic [STAMP_BITS-1:0] min_stamp;
        logic [IDX_BITS-1:0]   min_idx;
        logic [KEY_BITS-1:0]   min_key;
    } srch_rec_t;

    // slot write command broadcast to the cells
    typedef struct packed {
        logic                  en;
        logic [KEY_BITS-1:0]   key;
        logic [STAMP_BITS-1:0] stamp;
    } slot_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE
    } alrc_state_t;

endpackage

FILE: sv/alrc_cell.sv
// One cache slot: key, valid bit and stamp, plus one stage of the search record.
// Depends on alrc_pkg.
module alrc_cell (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [alrc_pkg::IDX_BITS-1:0]   cell_idx,
    input  logic                            cell_active,
    input  alrc_pkg::slot_wr_t              wr,
    input  alrc_pkg::srch_rec_t             rec_in,
    output alrc_pkg::srch_rec_t             rec_out
);
    import alrc_pkg::*;

    logic                  valid_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [STAMP_BITS-1:0] stamp_reg;
    srch_rec_t             rec_reg;
    srch_rec_t             rec_next;

    // fold this slot into the passing record; inactive slots forward it
    always_comb begin
        rec_next = rec_in;
        if (cell_active) begin
            if (!rec_in.hit && valid_reg && (key_reg == rec_in.key)) begin
                rec_next.hit     = 1'b1;
                rec_next.hit_idx = cell_idx;
            end
            if (!rec_in.free && !valid_reg) begin
                rec_next.free     = 1'b1;
                rec_next.free_idx = cell_idx;
            end
            // strict compare keeps the lowest index on equal stamps
            if (valid_reg && (!rec_in.have_min || (stamp_reg < rec_in.min_stamp))) begin
                rec_next.have_min  = 1'b1;
                rec_next.min_stamp = stamp_reg;
                rec_next.min_idx   = cell_idx;
                rec_next.min_key   = key_reg;
            end
        end
    end

    // advance the record to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg.pvalid <= 1'b0;
        end else begin
            rec_reg <= rec_next;
        end
    end

    // valid bit of the slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (wr.en) begin
            valid_reg <= 1'b1;
        end
    end

    // slot contents
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            key_reg   <= wr.key;
            stamp_reg <= wr.stamp;
        end
    end

    assign rec_out = rec_reg;

endmodule

FILE: sv/assoc_lru_mapping_cache.sv
// A new lookup is accepted only after the previous one has updated its slot. Its
// search record walks the chain of 16 slot cells one cell per cycle, waits in the tail
// register, then updates one slot and loads the result register once that is free.
// The result register frees the chain while a result waits to be taken.
// Reset (aresetn low, synchronous): valid bits, use counter and control clear,
// active_slots returns to 16; slot keys and stamps are not cleared.
module assoc_lru_mapping_cache (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // [31:0] lookup_key
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] hit, [1] evicted, [5:2] slot_index, [37:6] evicted_key, [39:38] zero
    output logic [alrc_pkg::OUT_BITS-1:0]    m_tdata,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [alrc_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [alrc_pkg::DATA_BITS-1:0]   pwdata,
    output logic [alrc_pkg::DATA_BITS-1:0]   prdata,
    output logic                             pready
);
    import alrc_pkg::*;

    alrc_state_t           state_reg;
    alrc_state_t           state_next;
    logic [CNT_BITS-1:0]   active_reg;
    logic [CNT_BITS-1:0]   n_eff;
    logic [STAMP_BITS-1:0] counter_reg;
    srch_rec_t             tail_reg;
    logic                  m_tvalid_reg;
    logic [OUT_BITS-1:0]   m_tdata_reg;

    srch_rec_t             rec_link [SLOTS+1];
    logic [SLOTS:0]        rec_vld;
    logic [SLOTS-1:0]      wr_en_vec;
    slot_wr_t              cell_wr [SLOTS];

    logic                  accept;
    logic                  capture;
    logic                  apply;
    logic                  cfg_wr;

    logic                  res_hit;
    logic                  res_ev;
    logic [IDX_BITS-1:0]   res_idx;
    logic [KEY_BITS-1:0]   res_evkey;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACTIVE_RESET;
        end else if (cfg_wr && (paddr[2] == REG_ACTIVE_SLOTS)) begin
            active_reg <= pwdata[CNT_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_ACTIVE_SLOTS) begin
            prdata = {{(DATA_BITS-CNT_BITS){1'b0}}, active_reg};
        end
    end

    // saturate the active count to 1..SLOTS
    always_comb begin
        if (active_reg < ACTIVE_MIN) begin
            n_eff = ACTIVE_MIN;
        end else if (active_reg > ACTIVE_RESET) begin
            n_eff = ACTIVE_RESET;
        end else begin
            n_eff = active_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (rec_link[SLOTS].pvalid) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready = 1'b0;
        capture  = 1'b0;
        apply    = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_SEARCH: capture  = rec_link[SLOTS].pvalid;
            ST_DECIDE: apply    = !m_tvalid_reg || m_tready;
            default:   s_tready = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // inject a fresh search record at the head of the chain
    always_comb begin
        rec_link[0]           = '0;
        rec_link[0].pvalid    = accept;
        rec_link[0].key       = s_tdata[KEY_BITS-1:0];
    end

    // chain of slot cells
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        assign wr_en_vec[i]     = apply && (res_idx == IDX_BITS'(i));
        assign cell_wr[i].en    = wr_en_vec[i];
        assign cell_wr[i].key   = tail_reg.key;
        assign cell_wr[i].stamp = counter_reg;

        alrc_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cell_idx    (IDX_BITS'(i)),
            .cell_active (CNT_BITS'(i) < n_eff),
            .wr          (cell_wr[i]),
            .rec_in      (rec_link[i]),
            .rec_out     (rec_link[i+1])
        );
    end

    for (genvar j = 0; j <= SLOTS; j++) begin : g_vld
        assign rec_vld[j] = rec_link[j].pvalid;
    end

    // hold the finished record until the slot update
    always_ff @(posedge aclk) begin
        if (capture) begin
            tail_reg <= rec_link[SLOTS];
        end
    end

    // pick hit, fill or eviction
    always_comb begin
        res_hit   = 1'b0;
        res_ev    = 1'b0;
        res_idx   = tail_reg.min_idx;
        res_evkey = '0;
        if (tail_reg.hit) begin
            res_hit = 1'b1;
            res_idx = tail_reg.hit_idx;
        end else if (tail_reg.free) begin
            res_idx = tail_reg.free_idx;
        end else begin
            res_ev    = 1'b1;
            res_evkey = tail_reg.min_key;
        end
    end

    // use counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= '0;
        end else if (apply) begin
            counter_reg <= counter_reg + STAMP_BITS'(1);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (apply) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (apply) begin
            m_tdata_reg <= {2'b00, res_evkey, res_idx, res_ev, res_hit};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // at most one search record is in the chain
    a_one_record: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(rec_vld) <= 1)
        else $error("more than one search record in flight");

    // chain is empty past the head while idle
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (rec_vld[SLOTS:1] == '0))
        else $error("search record left in chain while idle");

    // a slot update touches at most one cell
    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(wr_en_vec))
        else $error("several slots written at once");

    // a result is never both a hit and an eviction
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("result flags hit and eviction together");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for assoc_lru_mapping_cache: directed table, then random lookups.
// Depends on alrc_pkg and the cache RTL; predicts every result with its own LRU directory.
module testbench;
    import alrc_pkg::*;

    localparam int LATENCY      = SLOTS + 2;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 113;
    localparam int POOL_DEPTH   = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int PRESSURE_PH  = 4;
    localparam logic [ADDR_BITS-1:0] ACTIVE_ADDR = {REG_ACTIVE_SLOTS, 2'b00};

    // result fields, hit in the lowest bit as on m_tdata
    typedef struct packed {
        logic [KEY_BITS-1:0] evicted_key;
        logic [IDX_BITS-1:0] slot_index;
        logic                evicted;
        logic                hit;
    } lookup_result_t;

    typedef enum logic {
        ROW_LOOKUP,
        ROW_CONFIG
    } row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [31:0]         value;
        logic                typed;
        logic                want_hit;
        logic                want_evicted;
        logic [IDX_BITS-1:0] want_slot;
        logic [KEY_BITS-1:0] want_evkey;
    } dir_row_t;

    // directed rows: lookups from reset, eviction, saturated register values,
    // hidden duplicate keys and the lower-index win on a hit
    localparam int DIR_ROWS = 22;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{ROW_LOOKUP, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 4'd0, 32'h0000_0000},
        '{ROW_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 4'd1, 32'h0000_0000},
        '{ROW_LOOKUP, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 4'd0, 32'h0000_0000},
        '{ROW_CONFIG, 32'd2,         1'b0, 1'b0, 1'b0, 4'd0, 32'h0000_0000},
        '{ROW_LOOKUP, 32'h1234_5678, 1'b1, 1'b0, 1'b1, 4'd1, 32'hFFFF_FFFF},
        '{ROW_CONFIG, 32'd0,         1'b0, 1'b0, 1'b0, 4'd0, 32'h0000_0000},
        '{ROW_LOOKUP, 32'hA5A5_A5A5, 1'b1, 1'b0, 1'b1, 4'd0, 32'h0000_0000},
        '{ROW_LOOKUP, 32'h1234_5678, 1'b1, 1'b0, 1'b1, 4'd0, 32'hA5A5_A5A5},
        '{ROW_CONFIG, 32'd31,        1'b0, 1'b0, 1'b0, 4'd0, 32'h0000_0000},
        '{ROW_LOOKUP, 32'h1234_5678, 1'b1, 1'b1, 1'b0, 4'd0, 32'h0000_0000},
        '{ROW_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 4'd2, 32'h0000_0000},
        '{ROW_LOOKUP, 32'h5A5A_5A5A, 1'b1, 1'b0, 1'b0, 4'd3, 32'h0000_0000},
        '{ROW_LOOKUP, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 4'd0, 32'h0000_0000},
        '{ROW_LOOKUP, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 4'd0, 32'h0000_0000},
        '{ROW_LOOKUP, 32'hDEAD_BEEF, 1'b0, 1'b0, 1'b0, 4'd0, 32'h0000_0000},
        '{ROW_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 4'd0, 32'h0000_0000},
        '{ROW_CONFIG, 32'd2,         1'b0, 1'b0, 1'b0, 4'd0, 32'h0000_0000},
        '{ROW_LOOKUP, 32'h1234_5678, 1'b0, 1'b0, 1'b0, 4'd0, 32'h0000_0000},
        '{ROW_CONFIG, 32'd1,         1'b0, 1'b0, 1'b0, 4'd0, 32'h0000_0000},
        '{ROW_LOOKUP, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 4'd0, 32'h0000_0000},
        '{ROW_LOOKUP, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 4'd0, 32'h0000_0000},
        '{ROW_CONFIG, 32'd16,        1'b0, 1'b0, 1'b0, 4'd0, 32'h0000_0000}
    };

    // active_slots per random phase; one entry carries junk above bit 4
    localparam logic [31:0] ACTIVE_PLAN [PHASES] = '{
        32'd16, 32'd1, 32'd0, 32'd5, 32'd31, 32'd8, 32'hFFFF_FFE7, 32'd12, 32'd20, 32'd16
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;      // [31:0] lookup_key
    logic                 m_tvalid;
    logic                 m_tready;
    // [0] hit, [1] evicted, [5:2] slot_index, [37:6] evicted_key, [39:38] zero
    logic [OUT_BITS-1:0]  m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    // predictor state
    logic [KEY_BITS-1:0]   cache_key   [SLOTS];
    bit                    cache_live  [SLOTS];
    logic [STAMP_BITS-1:0] cache_stamp [SLOTS];
    logic [STAMP_BITS-1:0] lru_clock;
    logic [CNT_BITS-1:0]   cfg_active;

    lookup_result_t due_results [$];
    int             fault_count;
    int             gap_pct;
    int             stall_pct;
    bit             hold_req;

    assoc_lru_mapping_cache uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("assoc_lru_mapping_cache verification failed");
        $finish;
    end

    // saturate the register into 1..SLOTS
    function automatic int visible_slots();
        if (cfg_active < ACTIVE_MIN)
            return ACTIVE_MIN;
        if (cfg_active > SLOTS)
            return SLOTS;
        return cfg_active;
    endfunction

    // look the key up in the model directory and update it; stamps compare unsigned
    function automatic lookup_result_t lru_predict(input logic [KEY_BITS-1:0] key);
        int n;
        int victim;
        lookup_result_t r;
        n = visible_slots();
        r = '0;
        for (int i = 0; i < n; i++) begin
            if (cache_live[i] && cache_key[i] == key) begin
                cache_stamp[i] = lru_clock;
                lru_clock++;
                r.hit = 1'b1;
                r.slot_index = IDX_BITS'(i);
                return r;
            end
        end
        for (int i = 0; i < n; i++) begin
            if (!cache_live[i]) begin
                cache_live[i] = 1'b1;
                cache_key[i] = key;
                cache_stamp[i] = lru_clock;
                lru_clock++;
                r.slot_index = IDX_BITS'(i);
                return r;
            end
        end
        victim = 0;
        for (int i = 1; i < n; i++) begin
            if (cache_stamp[i] < cache_stamp[victim])
                victim = i;
        end
        r.evicted = 1'b1;
        r.slot_index = IDX_BITS'(victim);
        r.evicted_key = cache_key[victim];
        cache_key[victim] = key;
        cache_stamp[victim] = lru_clock;
        lru_clock++;
        return r;
    endfunction

    // offer one key, hold it until the transfer, then predict its result
    task automatic offer_key(input logic [KEY_BITS-1:0] key, output lookup_result_t predicted);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        do @(posedge aclk); while (!s_tready);
        predicted = lru_predict(key);
    endtask

    // stop offering and wait until every result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge aclk);
    endtask

    // APB write of active_slots: setup, then access until pready
    task automatic write_active(input logic [DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ACTIVE_ADDR;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_active = value[CNT_BITS-1:0];
    endtask

    // receiver: random stalls, or a long hold-off when asked
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        lookup_result_t want;
        lookup_result_t seen;
        if (aresetn && m_tvalid && m_tready) begin
            seen = m_tdata[$bits(lookup_result_t)-1:0];
            if (due_results.size() == 0) begin
                $error("result with no lookup outstanding: m_tdata=%h", m_tdata);
                fault_count++;
            end else begin
                want = due_results.pop_front();
                if (seen.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, seen.hit);
                    fault_count++;
                end
                if (seen.evicted !== want.evicted) begin
                    $error("evicted: expected %0d, got %0d", want.evicted, seen.evicted);
                    fault_count++;
                end
                if (seen.slot_index !== want.slot_index) begin
                    $error("slot_index: expected %0d, got %0d", want.slot_index,
                           seen.slot_index);
                    fault_count++;
                end
                if (seen.evicted_key !== want.evicted_key) begin
                    $error("evicted_key: expected %h, got %h", want.evicted_key,
                           seen.evicted_key);
                    fault_count++;
                end
            end
        end
    end

    initial begin
        lookup_result_t      got;
        logic [KEY_BITS-1:0] key_pool [POOL_DEPTH];
        logic [KEY_BITS-1:0] key;
        int                  pool_span;
        int                  pick;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        hold_req = 1'b0;
        fault_count = 0;
        gap_pct   = 19;
        stall_pct = 19;
        for (int i = 0; i < SLOTS; i++) begin
            cache_live[i]  = 1'b0;
            cache_key[i]   = '0;
            cache_stamp[i] = '0;
        end
        lru_clock  = '0;
        cfg_active = ACTIVE_RESET;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table; register writes only once the block has gone idle
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_CONFIG) begin
                drain_results();
                write_active(DIRECTED[r].value);
            end else begin
                offer_key(DIRECTED[r].value, got);
                if (DIRECTED[r].typed) begin
                    got.hit         = DIRECTED[r].want_hit;
                    got.evicted     = DIRECTED[r].want_evicted;
                    got.slot_index  = DIRECTED[r].want_slot;
                    got.evicted_key = DIRECTED[r].want_evkey;
                end
                due_results.push_back(got);
            end
        end

        // random phases: keys mostly from a pool a little larger than the
        // visible slots, so hits, fills and evictions all stay frequent
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            write_active(ACTIVE_PLAN[ph]);
            case (ph % 4)
                0: begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    gap_pct = 45;
                    stall_pct = 0;
                end
                2: begin
                    gap_pct = 0;
                    stall_pct = 45;
                end
                default: begin
                    gap_pct = 19;
                    stall_pct = 19;
                end
            endcase
            if (ph == PRESSURE_PH)
                hold_req = 1'b1;
            // keep part of the pool so that hidden slots can come back into view
            for (int i = 0; i < POOL_DEPTH; i++) begin
                if (ph == 0 || $urandom_range(1) == 1)
                    key_pool[i] = $urandom();
            end
            pool_span = visible_slots() + $urandom_range(0, 4);
            if (pool_span > POOL_DEPTH)
                pool_span = POOL_DEPTH;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(99);
                if (pick < 80)
                    key = key_pool[$urandom_range(pool_span - 1)];
                else if (pick < 92)
                    key = $urandom();
                else if (pick < 96)
                    key = '0;
                else
                    key = '1;
                offer_key(key, got);
                due_results.push_back(got);
            end
        end

        // let stray results show up before the verdict
        drain_results();
        repeat (2 * LATENCY) @(posedge aclk);
        if (fault_count == 0)
            $display("assoc_lru_mapping_cache verification clean");
        else
            $display("assoc_lru_mapping_cache verification failed");
        $finish;
    end

endmodule
